### rtl/core/vp8d_pkg.sv
// ----------------------------------------------------------------------------
// VP8 RTP depacketizer package
// Shared payload types and status codes for the depacketizer blocks.
// ----------------------------------------------------------------------------
package vp8d_pkg;

    // Number of size bits below the 2-bit scale in a keyframe dimension.
    localparam int SIZE_BITS = 14;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_START_MISM = 3'd1;
    localparam logic [2:0] STATUS_INTER_EARLY = 3'd2;
    localparam logic [2:0] STATUS_NO_FRAME   = 3'd3;
    localparam logic [2:0] STATUS_TRUNCATED  = 3'd4;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        packet_first;
        logic        packet_last;
        logic        rtp_new_frame;
        logic        rtp_marker;
        logic [31:0] rtp_timestamp;
    } in_item_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic        frame_first;
        logic        frame_last;
        logic        key_frame;
        logic [31:0] frame_time;
        logic [2+SIZE_BITS-1:0] frame_width;
        logic [2+SIZE_BITS-1:0] frame_height;
        logic        packet_done;
        logic [2:0]  packet_status;
    } out_item_t;

endpackage

### rtl/core/vp8d_parser.sv
// ----------------------------------------------------------------------------
// VP8 RTP depacketizer parser
// Holds the descriptor and frame state and builds at most one result per request.
// ----------------------------------------------------------------------------
module vp8d_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  vp8d_pkg::in_item_t  item,
    output logic                has_result,
    output vp8d_pkg::out_item_t result
);
    import vp8d_pkg::*;

    typedef enum logic [3:0] {
        PH_DESC,
        PH_EXT,
        PH_PID,
        PH_PIDX,
        PH_TL0,
        PH_TK,
        PH_PHDR,
        PH_KHDR,
        PH_DATA,
        PH_DROP
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [2:0] err;
    } body_t;

    phase_t      phase_reg, phase_next;
    logic        flag_s_reg, flag_s_next;
    logic        flag_i_reg, flag_i_next;
    logic        flag_l_reg, flag_l_next;
    logic        flag_tk_reg, flag_tk_next;
    logic [3:0]  hpos_reg, hpos_next;
    logic [2:0]  error_reg, error_next;
    logic        open_reg, open_next;
    logic        seen_key_reg, seen_key_next;
    logic        is_key_reg, is_key_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [15:0] cur_w_reg, cur_w_next;
    logic [15:0] cur_h_reg, cur_h_next;
    logic [15:0] prev_w_reg, prev_w_next;
    logic [15:0] prev_h_reg, prev_h_next;

    phase_t      phase_in;
    body_t       body;
    logic        emit;
    logic        ffirst;
    logic        flast;
    logic        done;
    logic        inter;
    logic [3:0]  hpos_inc;

    // Descriptor finished: decide how the remaining bytes are handled.
    // An error code of zero leaves the packet error as it is.
    function automatic body_t enter_body(input logic s, input logic nf, input logic fo);
        body_t r;
        r.err = STATUS_OK;
        if (s) begin
            if (!nf) begin
                r.phase = PH_DROP;
                r.err   = STATUS_START_MISM;
            end
            else begin
                r.phase = PH_PHDR;
            end
        end
        else if (!fo) begin
            r.phase = PH_DROP;
            r.err   = STATUS_NO_FRAME;
        end
        else begin
            r.phase = PH_DATA;
        end
        return r;
    endfunction

    // Skip to the next optional descriptor byte after the given level.
    function automatic body_t advance(input logic [1:0] level, input logic fi,
                                      input logic fl, input logic ftk,
                                      input logic s, input logic nf, input logic fo);
        body_t r;
        r.err = STATUS_OK;
        if (level < 2'd1 && fi) begin
            r.phase = PH_PID;
        end
        else if (level < 2'd2 && fl) begin
            r.phase = PH_TL0;
        end
        else if (level < 2'd3 && ftk) begin
            r.phase = PH_TK;
        end
        else begin
            r = enter_body(s, nf, fo);
        end
        return r;
    endfunction

    always_comb
    begin
        phase_next    = phase_reg;
        flag_s_next   = flag_s_reg;
        flag_i_next   = flag_i_reg;
        flag_l_next   = flag_l_reg;
        flag_tk_next  = flag_tk_reg;
        hpos_next     = hpos_reg;
        error_next    = error_reg;
        open_next     = open_reg;
        seen_key_next = seen_key_reg;
        is_key_next   = is_key_reg;
        stamp_next    = stamp_reg;
        cur_w_next    = cur_w_reg;
        cur_h_next    = cur_h_reg;
        prev_w_next   = prev_w_reg;
        prev_h_next   = prev_h_reg;
        emit          = 1'b0;
        ffirst        = 1'b0;
        flast         = 1'b0;
        done          = 1'b0;
        inter         = item.data_byte[0];
        hpos_inc      = hpos_reg + 4'd1;
        body.phase    = PH_DROP;
        body.err      = STATUS_OK;

        phase_in = item.packet_first ? PH_DESC : phase_reg;

        case (phase_in)
            PH_DESC:
            begin
                error_next   = STATUS_OK;
                flag_s_next  = item.data_byte[4];
                flag_i_next  = 1'b0;
                flag_l_next  = 1'b0;
                flag_tk_next = 1'b0;
                if (item.data_byte[7]) begin
                    phase_next = PH_EXT;
                end
                else begin
                    body = enter_body(item.data_byte[4], item.rtp_new_frame, open_reg);
                end
            end
            PH_EXT:
            begin
                flag_i_next  = item.data_byte[7];
                flag_l_next  = item.data_byte[6];
                flag_tk_next = |item.data_byte[5:4];
                body = advance(2'd0, item.data_byte[7], item.data_byte[6],
                               |item.data_byte[5:4], flag_s_reg,
                               item.rtp_new_frame, open_reg);
            end
            PH_PID:
            begin
                if (item.data_byte[7]) begin
                    phase_next = PH_PIDX;
                end
                else begin
                    body = advance(2'd1, flag_i_reg, flag_l_reg, flag_tk_reg, flag_s_reg,
                                   item.rtp_new_frame, open_reg);
                end
            end
            PH_PIDX:
            begin
                body = advance(2'd1, flag_i_reg, flag_l_reg, flag_tk_reg, flag_s_reg,
                               item.rtp_new_frame, open_reg);
            end
            PH_TL0:
            begin
                body = advance(2'd2, flag_i_reg, flag_l_reg, flag_tk_reg, flag_s_reg,
                               item.rtp_new_frame, open_reg);
            end
            PH_TK:
            begin
                body = advance(2'd3, flag_i_reg, flag_l_reg, flag_tk_reg, flag_s_reg,
                               item.rtp_new_frame, open_reg);
            end
            PH_PHDR:
            begin
                if (hpos_reg == 4'd0 && inter && !seen_key_reg) begin
                    error_next = STATUS_INTER_EARLY;
                    phase_next = PH_DROP;
                end
                else begin
                    if (hpos_reg == 4'd0) begin
                        open_next   = 1'b1;
                        is_key_next = !inter;
                        stamp_next  = item.rtp_timestamp;
                        cur_w_next  = inter ? prev_w_reg : 16'd0;
                        cur_h_next  = inter ? prev_h_reg : 16'd0;
                        ffirst      = 1'b1;
                    end
                    emit      = 1'b1;
                    hpos_next = hpos_inc;
                    if (hpos_inc >= 4'd3) begin
                        hpos_next  = 4'd0;
                        phase_next = is_key_next ? PH_KHDR : PH_DATA;
                    end
                end
            end
            PH_KHDR:
            begin
                emit = 1'b1;
                case (hpos_reg)
                    4'd3:    cur_w_next = {cur_w_reg[15:8], item.data_byte};
                    4'd4:    cur_w_next = {item.data_byte, cur_w_reg[7:0]};
                    4'd5:    cur_h_next = {cur_h_reg[15:8], item.data_byte};
                    4'd6:    cur_h_next = {item.data_byte, cur_h_reg[7:0]};
                    default: ;
                endcase
                hpos_next = hpos_inc;
                if (hpos_inc >= 4'd7) begin
                    hpos_next     = 4'd0;
                    prev_w_next   = cur_w_next;
                    prev_h_next   = cur_h_next;
                    seen_key_next = 1'b1;
                    phase_next    = PH_DATA;
                end
            end
            PH_DATA:
            begin
                emit = open_reg;
            end
            default:
            begin
                phase_next = PH_DROP;
            end
        endcase

        // Descriptor bytes that finish the descriptor pick the body phase here.
        if (phase_in == PH_DESC || phase_in == PH_EXT || phase_in == PH_PID ||
            phase_in == PH_PIDX || phase_in == PH_TL0 || phase_in == PH_TK) begin
            if (!(phase_in == PH_DESC && item.data_byte[7]) &&
                !(phase_in == PH_PID && item.data_byte[7])) begin
                phase_next = body.phase;
                if (body.err != STATUS_OK) begin
                    error_next = body.err;
                end
                if (body.phase == PH_PHDR) begin
                    hpos_next = 4'd0;
                end
            end
        end

        if (item.packet_last) begin
            done = 1'b1;
            if (phase_next != PH_DATA && phase_next != PH_DROP && error_next == STATUS_OK) begin
                error_next = STATUS_TRUNCATED;
                if (phase_next == PH_KHDR || (phase_next == PH_PHDR && hpos_next != 4'd0)) begin
                    open_next = 1'b0;
                end
            end
            else if (error_next == STATUS_OK && item.rtp_marker && open_next) begin
                flast     = 1'b1;
                open_next = 1'b0;
            end
            phase_next = PH_DESC;
            hpos_next  = 4'd0;
        end

        has_result           = emit || done;
        result.byte_valid    = emit;
        result.out_byte      = emit ? item.data_byte : 8'd0;
        result.frame_first   = ffirst;
        result.frame_last    = flast;
        result.key_frame     = is_key_next;
        result.frame_time    = stamp_next;
        result.frame_width   = cur_w_next;
        result.frame_height  = cur_h_next;
        result.packet_done   = done;
        result.packet_status = done ? error_next : STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg    <= PH_DESC;
            flag_s_reg   <= 1'b0;
            flag_i_reg   <= 1'b0;
            flag_l_reg   <= 1'b0;
            flag_tk_reg  <= 1'b0;
            hpos_reg     <= 4'd0;
            error_reg    <= STATUS_OK;
            open_reg     <= 1'b0;
            seen_key_reg <= 1'b0;
            is_key_reg   <= 1'b0;
            stamp_reg    <= 32'd0;
            cur_w_reg    <= 16'd0;
            cur_h_reg    <= 16'd0;
            prev_w_reg   <= 16'd0;
            prev_h_reg   <= 16'd0;
        end
        else if (accept) begin
            phase_reg    <= phase_next;
            flag_s_reg   <= flag_s_next;
            flag_i_reg   <= flag_i_next;
            flag_l_reg   <= flag_l_next;
            flag_tk_reg  <= flag_tk_next;
            hpos_reg     <= hpos_next;
            error_reg    <= error_next;
            open_reg     <= open_next;
            seen_key_reg <= seen_key_next;
            is_key_reg   <= is_key_next;
            stamp_reg    <= stamp_next;
            cur_w_reg    <= cur_w_next;
            cur_h_reg    <= cur_h_next;
            prev_w_reg   <= prev_w_next;
            prev_h_reg   <= prev_h_next;
        end
    end

endmodule

### rtl/core/vp8d_out_buf.sv
// ----------------------------------------------------------------------------
// VP8 RTP depacketizer output buffer
// Result register with a skid entry; the input side waits on ready only while the skid entry is occupied.
// ----------------------------------------------------------------------------
module vp8d_out_buf
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  vp8d_pkg::out_item_t push_data,
    output logic                can_push,
    output logic                out_valid,
    input  logic                out_ready,
    output vp8d_pkg::out_item_t out_data
);
    import vp8d_pkg::*;

    logic      head_valid_reg;
    logic      skid_valid_reg;
    out_item_t head_reg;
    out_item_t skid_reg;
    logic      head_free;

    assign head_free = !head_valid_reg || out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (head_free) begin
            if (skid_valid_reg) begin
                head_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else begin
                head_valid_reg <= push;
            end
        end
        else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_free) begin
            head_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push) begin
            skid_reg <= push_data;
        end
    end

endmodule

### rtl/core/vp8_rtp_depacketizer.sv
// ----------------------------------------------------------------------------
// VP8 RTP depacketizer
// Strips the VP8 payload descriptor and passes frame bytes with frame status.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_ready, in_data) carries one RTP
// payload byte per request together with its packet-boundary flags, the RTP
// new-frame flag, the marker and the packet timestamp. The output channel
// (out_valid, out_ready, out_data) carries at most one result per input
// request: a frame byte, a packet status on the packet's last byte, or both.
// Descriptor bytes, and bytes of dropped packets that are not a packet's last
// byte, produce no result.
// The parser takes one byte per cycle while in_ready is high. Each result is
// registered in the result register or the skid entry. Parser state advances
// on every accepted request, so a new byte can follow in the very next cycle.
// The output stage is a result register backed by one skid entry; in_ready
// drops only while the skid entry is occupied, i.e. after the receiver has
// stalled with a result already waiting. When the receiver stalls, at most
// two results are held and nothing is lost or repeated.
// Reset clears the parser to expect a descriptor's first byte, forgets any
// open frame and previous keyframe size, and empties the output stage.
// ----------------------------------------------------------------------------
module vp8_rtp_depacketizer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vp8d_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vp8d_pkg::out_item_t out_data
);
    import vp8d_pkg::*;

    logic      accept;
    logic      has_result;
    logic      can_push;
    out_item_t result;

    // The parser commits its state on every accepted request.
    assign in_ready = can_push;
    assign accept   = in_valid && in_ready;

    vp8d_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (in_data),
        .has_result (has_result),
        .result     (result)
    );

    vp8d_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept && has_result),
        .push_data  (result),
        .can_push   (can_push),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // A frame can only start on a byte that is passed through.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.frame_first || out_data.byte_valid))
        else $error("frame_first without a frame byte");

    // Frame end and error status are only reported on a packet's last byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.frame_last || out_data.packet_status != STATUS_OK)
        |-> out_data.packet_done)
        else $error("frame_last or status outside packet end");

    // A completed frame is always reported with a good status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_last |-> out_data.packet_status == STATUS_OK)
        else $error("frame_last on a failed packet");

    // The input side stalls only when a result is waiting on a stalled receiver.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && $past(out_valid && !out_ready))
        else $error("input stalled without a waiting result");

endmodule

### verif/vp8_rtp_depacketizer_test.sv
// ----------------------------------------------------------------------------
// VP8 RTP depacketizer testbench
// Feeds payload byte requests to the depacketizer, predicts every result from
// a cycle-free model of the descriptor parser and frame state, and compares
// each result, field by field, under random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vp8_rtp_depacketizer_test;
    import vp8d_pkg::*;

    // Where the parser stands inside a packet.
    typedef enum logic [3:0]
    {
        P_DESCRIPTOR,
        P_EXTENSION,
        P_PICTURE_ID,
        P_PICTURE_ID_LOW,
        P_TL0_INDEX,
        P_TID_KEYIDX,
        P_PAYLOAD_HDR,
        P_KEY_HDR,
        P_FRAME_DATA,
        P_DISCARD
    } parse_stage_e;

    // Descriptor flags as the parser keeps them.
    localparam logic [7:0] DESC_START  = 8'h01;
    localparam logic [7:0] DESC_PICID  = 8'h80;
    localparam logic [7:0] DESC_TL0    = 8'h40;
    localparam logic [7:0] DESC_TIDKEY = 8'h20;

    // A cycle in which neither channel moves a request counts toward this.
    localparam int STALL_LIMIT     = 4000;
    // Cycles allowed after the last expected result for stray results.
    localparam int DRAIN_CYCLES    = 20;
    localparam int ITEMS_PER_PHASE = 567;

    // ------------------------------------------------------------------------
    // Scoreboard: carries its own copy of the parser and frame state, turns
    // each accepted request into zero or one expected result, and checks the
    // results in order.
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        parse_stage_e stage      = P_DESCRIPTOR;
        logic [7:0]   desc_flags = '0;
        logic [3:0]   hdr_pos    = '0;
        logic [2:0]   pkt_err    = STATUS_OK;
        bit           frame_open = 0;
        bit           seen_key   = 0;
        bit           frame_key  = 0;
        logic [31:0]  frame_stamp = '0;
        logic [15:0]  cur_width  = '0;
        logic [15:0]  cur_height = '0;
        logic [15:0]  prev_width = '0;
        logic [15:0]  prev_height = '0;
        out_item_t    expected_q[$];
        int           errors = 0;

        // The descriptor is complete; decide what the packet body is.
        function void finish_descriptor(bit new_frame);
            if ((desc_flags & DESC_START) != 0)
            begin
                if (!new_frame)
                begin
                    pkt_err = STATUS_START_MISM;
                    stage = P_DISCARD;
                end
                else
                begin
                    stage = P_PAYLOAD_HDR;
                    hdr_pos = '0;
                end
            end
            else if (!frame_open)
            begin
                pkt_err = STATUS_NO_FRAME;
                stage = P_DISCARD;
            end
            else
                stage = P_FRAME_DATA;
        endfunction

        // Step to the next optional descriptor byte that is present.
        function void skip_optional(int done_count, bit new_frame);
            if (done_count < 1 && (desc_flags & DESC_PICID) != 0)
                stage = P_PICTURE_ID;
            else if (done_count < 2 && (desc_flags & DESC_TL0) != 0)
                stage = P_TL0_INDEX;
            else if (done_count < 3 && (desc_flags & DESC_TIDKEY) != 0)
                stage = P_TID_KEYIDX;
            else
                finish_descriptor(new_frame);
        endfunction

        function void note_request(in_item_t req);
            out_item_t  want;
            logic [7:0] b;
            bit         emit;
            bit         ffirst;
            bit         flast;
            bit         done;
            logic [2:0] status;

            b = req.data_byte;
            emit = 0;
            ffirst = 0;
            flast = 0;
            done = 0;
            status = STATUS_OK;

            if (req.packet_first)
                stage = P_DESCRIPTOR;

            case (stage)
                P_DESCRIPTOR:
                begin
                    pkt_err = STATUS_OK;
                    desc_flags = b[4] ? DESC_START : 8'h00;
                    if (b[7])
                        stage = P_EXTENSION;
                    else
                        finish_descriptor(req.rtp_new_frame);
                end
                P_EXTENSION:
                begin
                    desc_flags = desc_flags | (b & (DESC_PICID | DESC_TL0)) |
                                 ((b[5] || b[4]) ? DESC_TIDKEY : 8'h00);
                    skip_optional(0, req.rtp_new_frame);
                end
                P_PICTURE_ID:
                begin
                    if (b[7])
                        stage = P_PICTURE_ID_LOW;
                    else
                        skip_optional(1, req.rtp_new_frame);
                end
                P_PICTURE_ID_LOW: skip_optional(1, req.rtp_new_frame);
                P_TL0_INDEX:      skip_optional(2, req.rtp_new_frame);
                P_TID_KEYIDX:     skip_optional(3, req.rtp_new_frame);
                P_PAYLOAD_HDR:
                begin
                    if (hdr_pos == 0 && b[0] && !seen_key)
                    begin
                        // An interframe with no keyframe yet is dropped, but
                        // whatever frame is open stays open.
                        pkt_err = STATUS_INTER_EARLY;
                        stage = P_DISCARD;
                    end
                    else
                    begin
                        if (hdr_pos == 0)
                        begin
                            frame_open = 1;
                            frame_key = !b[0];
                            frame_stamp = req.rtp_timestamp;
                            cur_width = b[0] ? prev_width : 16'h0000;
                            cur_height = b[0] ? prev_height : 16'h0000;
                            ffirst = 1;
                        end
                        emit = 1;
                        hdr_pos++;
                        if (hdr_pos >= 3)
                        begin
                            hdr_pos = '0;
                            stage = frame_key ? P_KEY_HDR : P_FRAME_DATA;
                        end
                    end
                end
                P_KEY_HDR:
                begin
                    emit = 1;
                    case (hdr_pos)
                        4'd3: cur_width[7:0] = b;
                        4'd4: cur_width[15:8] = b;
                        4'd5: cur_height[7:0] = b;
                        4'd6: cur_height[15:8] = b;
                        default: ;
                    endcase
                    hdr_pos++;
                    if (hdr_pos >= 7)
                    begin
                        hdr_pos = '0;
                        prev_width = cur_width;
                        prev_height = cur_height;
                        seen_key = 1;
                        stage = P_FRAME_DATA;
                    end
                end
                P_FRAME_DATA: emit = frame_open;
                default:      stage = P_DISCARD;
            endcase

            if (req.packet_last)
            begin
                done = 1;
                if (stage != P_FRAME_DATA && stage != P_DISCARD && pkt_err == STATUS_OK)
                begin
                    // The packet ended inside a header. A frame that this
                    // packet had opened is closed again without an end.
                    pkt_err = STATUS_TRUNCATED;
                    if (stage == P_KEY_HDR || (stage == P_PAYLOAD_HDR && hdr_pos != 0))
                        frame_open = 0;
                end
                else if (pkt_err == STATUS_OK && req.rtp_marker && frame_open)
                begin
                    flast = 1;
                    frame_open = 0;
                end
                status = pkt_err;
                stage = P_DESCRIPTOR;
                hdr_pos = '0;
            end

            if (emit || done)
            begin
                want.byte_valid = emit;
                want.out_byte = emit ? b : 8'h00;
                want.frame_first = ffirst;
                want.frame_last = flast;
                want.key_frame = frame_key;
                want.frame_time = frame_stamp;
                want.frame_width = cur_width;
                want.frame_height = cur_height;
                want.packet_done = done;
                want.packet_status = status;
                expected_q.push_back(want);
            end
        endfunction

        function void check_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("time %0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;

            if (expected_q.size() == 0)
            begin
                errors++;
                $display("time %0t: unexpected result, expected none, got 0x%0h",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            check_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
            check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
            check_field("frame_first", 32'(want.frame_first), 32'(got.frame_first));
            check_field("frame_last", 32'(want.frame_last), 32'(got.frame_last));
            check_field("key_frame", 32'(want.key_frame), 32'(got.key_frame));
            check_field("frame_time", want.frame_time, got.frame_time);
            check_field("frame_width", 32'(want.frame_width), 32'(got.frame_width));
            check_field("frame_height", 32'(want.frame_height),
                        32'(got.frame_height));
            check_field("packet_done", 32'(want.packet_done), 32'(got.packet_done));
            check_field("packet_status", 32'(want.packet_status),
                        32'(got.packet_status));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the two channels. Every input of the block starts at
    // a known value; from then on the stimulus drives them with nonblocking
    // assignments right after a rising edge.
    // ------------------------------------------------------------------------
    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    frame_scoreboard sb;
    int          stall_cycles = 0;
    int          items_sent = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    // Bytes of the packet under construction.
    logic [7:0]  pkt_bytes[$];

    always #1 clk = ~clk;

    vp8_rtp_depacketizer uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // The receiver stalls at random, one decision per cycle.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Monitor. At the rising edge every process still sees the values from
    // before the edge, which are exactly the ones that decide whether a
    // request or a result moves at that edge. Accepted requests feed the
    // predictor; accepted results are checked against the oldest
    // expectation. The result of a request always comes at a later edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Watchdog: the run is declared hung when nothing moves for too long.
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("vp8_rtp_depacketizer_test: done, errors");
        $finish;
    end

    // Offer one request and return at the edge that accepts it. Valid is
    // left high on return, so a request that follows without a gap keeps it
    // high with no drop in between.
    task push_request(input in_item_t req);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Send the bytes in pkt_bytes as one packet. With scramble set, every
    // byte gets random packet flags, RTP flags and timestamp instead.
    task send_packet(input bit new_frame, input bit marker, input logic [31:0] stamp,
                     input bit with_first, input bit with_last, input bit scramble);
        in_item_t req;

        for (int i = 0; i < pkt_bytes.size(); i++)
        begin
            req.data_byte = pkt_bytes[i];
            if (scramble)
            begin
                req.packet_first = ($urandom_range(9, 0) == 0);
                req.packet_last = ($urandom_range(6, 0) == 0);
                req.rtp_new_frame = 1'($urandom_range(1, 0));
                req.rtp_marker = 1'($urandom_range(1, 0));
                req.rtp_timestamp = $urandom;
            end
            else
            begin
                req.packet_first = with_first && (i == 0);
                req.packet_last = with_last && (i == pkt_bytes.size() - 1);
                req.rtp_new_frame = new_frame;
                req.rtp_marker = marker;
                req.rtp_timestamp = stamp;
            end
            push_request(req);
        end
    endtask

    // Build a well-formed packet with random content: a descriptor with a
    // random choice of optional bytes, the payload header and, for a
    // keyframe, the keyframe header on a start packet, then a few data bytes.
    task build_packet(input bit start, input bit key);
        logic [7:0] desc;
        logic [7:0] ext;
        logic [7:0] pid;
        int         data_count;

        pkt_bytes.delete();
        desc = 8'($urandom);
        desc[4] = start;
        desc[7] = 1'($urandom_range(1, 0));
        pkt_bytes.push_back(desc);
        if (desc[7])
        begin
            ext = 8'($urandom);
            pkt_bytes.push_back(ext);
            if (ext[7])
            begin
                pid = 8'($urandom);
                pkt_bytes.push_back(pid);
                if (pid[7])
                    pkt_bytes.push_back(8'($urandom));
            end
            if (ext[6])
                pkt_bytes.push_back(8'($urandom));
            if (ext[5] || ext[4])
                pkt_bytes.push_back(8'($urandom));
        end
        if (start)
        begin
            desc = 8'($urandom);
            desc[0] = !key;
            pkt_bytes.push_back(desc);
            pkt_bytes.push_back(8'($urandom));
            pkt_bytes.push_back(8'($urandom));
            if (key)
                repeat (7) pkt_bytes.push_back(8'($urandom));
        end
        data_count = $urandom_range(6, 0);
        repeat (data_count) pkt_bytes.push_back(8'($urandom));
    endtask

    // One frame of one to three packets. Most packets go out intact; the
    // rest are cut short (with or without a last byte), lose their first
    // flag, carry the wrong new-frame flag, or get random flags throughout.
    task send_frame();
        bit          key;
        bit          marker;
        int          packet_count;
        int          pick;
        int          cut;
        logic [31:0] stamp;

        key = ($urandom_range(99, 0) < 30);
        packet_count = $urandom_range(3, 1);
        stamp = $urandom;
        if ($urandom_range(19, 0) == 0)
            stamp = $urandom_range(1, 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        for (int p = 0; p < packet_count; p++)
        begin
            build_packet(p == 0, key);
            // Now and then the frame is left without its marker.
            marker = (p == packet_count - 1) && ($urandom_range(9, 0) != 0);
            pick = $urandom_range(99, 0);
            if (pick < 85)
                send_packet(p == 0, marker, stamp, 1, 1, 0);
            else
            begin
                case ((pick - 85) / 3)
                    0, 1:
                    begin
                        cut = $urandom_range(pkt_bytes.size(), 1);
                        while (pkt_bytes.size() > cut)
                            void'(pkt_bytes.pop_back());
                        // Without a last byte the packet is abandoned when
                        // the next one starts.
                        send_packet(p == 0, marker, stamp, 1, pick < 88, 0);
                    end
                    2:       send_packet(p == 0, marker, stamp, 0, 1, 0);
                    3:       send_packet(p != 0, marker, stamp, 1, 1, 0);
                    default: send_packet(p == 0, marker, stamp, 1, 1, 1);
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int target;

        sb = new;
        send_idle_pct = 33;
        recv_idle_pct = 87;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests. An interframe before any keyframe is dropped
        // with its own status.
        pkt_bytes = {8'h10, 8'h01, 8'h55};
        send_packet(1, 0, 32'h0000_0000, 1, 1, 0);
        // A packet without the start bit while no frame is open.
        pkt_bytes = {8'h00};
        send_packet(0, 1, 32'h0000_0000, 1, 1, 0);
        // Start bit set but the RTP layer does not flag a new frame.
        pkt_bytes = {8'h10, 8'hAA};
        send_packet(0, 0, 32'hFFFF_FFFF, 1, 1, 0);
        // A full keyframe in one packet: every optional descriptor byte with
        // a two-byte picture ID, then the payload and keyframe headers with
        // scale bits set in the height, then one data byte and the marker.
        pkt_bytes = {8'h90, 8'hF0, 8'h80, 8'h12, 8'h34, 8'h56,
                     8'h00, 8'h9D, 8'h01,
                     8'h9D, 8'h01, 8'h2A, 8'h80, 8'h02, 8'hE0, 8'hC1,
                     8'hFF};
        send_packet(1, 1, 32'hFFFF_FFFF, 1, 1, 0);
        // A keyframe that ends inside its payload header.
        pkt_bytes = {8'h10, 8'h00};
        send_packet(1, 1, 32'h8000_0001, 1, 1, 0);

        // Random part in three idling phases.
        for (int phase_idx = 0; phase_idx < 3; phase_idx++)
        begin
            if (phase_idx == 1)
            begin
                send_idle_pct = 87;
                recv_idle_pct = 33;
            end
            else if (phase_idx == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
                send_frame();
        end
        in_valid <= 1'b0;

        // Let every expected result arrive; the watchdog covers a hang. Then
        // give the block a few more cycles to show any stray result.
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("vp8_rtp_depacketizer_test: done, clean");
        else
            $display("vp8_rtp_depacketizer_test: done, errors");
        $finish;
    end

endmodule

### vp8_rtp_depacketizer.f
rtl/core/vp8d_pkg.sv
rtl/core/vp8d_parser.sv
rtl/core/vp8d_out_buf.sv
rtl/core/vp8_rtp_depacketizer.sv
verif/vp8_rtp_depacketizer_test.sv
